// ----- rtl/serial_packet_axis_mapper_defines.svh -----
// Assertion macros for the serial packet axis mapper RTL.
`ifndef SERIAL_PACKET_AXIS_MAPPER_DEFINES_SVH
`define SERIAL_PACKET_AXIS_MAPPER_DEFINES_SVH

// Same-cycle implication, checked outside reset (expects clk and rst_n in scope).
`define SPAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset (expects clk and rst_n in scope).
`define SPAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/spam_pkg.sv -----
// Shared types and constants for the serial packet axis mapper.
package spam_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned UAXIS_W = 15;
  localparam int unsigned SAXIS_W = 16;

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'hFF;

  // Packet phase codes
  localparam logic [PHASE_W-1:0] PH_HUNT     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_THROTTLE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BRAKE    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_STEER    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CHECK    = 3'd4;

  // Raw payload of one good packet, passed from framer to scaler
  typedef struct packed {
    logic [BYTE_W-1:0] throttle;
    logic [BYTE_W-1:0] brake;
    logic [BYTE_W-1:0] steering;
  } packet_t;

endpackage

// ----- rtl/spam_framer.sv -----
// Front end: marker hunt, payload capture and checksum test.
module spam_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spam_pkg::BYTE_W-1:0]   cfg_start_marker,
  input  logic                          byte_accept,
  input  logic [spam_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          link_up,
  output logic                          pkt_valid,
  output spam_pkg::packet_t             pkt
);
  import spam_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTE_W-1:0]  marker_r;
  logic [BYTE_W-1:0]  thr_r, brk_r, str_r;
  logic [BYTE_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_we) begin
      marker_r <= cfg_start_marker;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else if (byte_accept) begin
      phase_r <= phase_nxt;
    end
  end

  // Payload bytes need no reset: the phase only reaches the check after all three land
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      if (phase_r == PH_THROTTLE) thr_r <= rx_byte;
      if (phase_r == PH_BRAKE)    brk_r <= rx_byte;
      if (phase_r == PH_STEER)    str_r <= rx_byte;
    end
  end

  always_comb begin
    case (phase_r)
      PH_THROTTLE: phase_nxt = PH_BRAKE;
      PH_BRAKE:    phase_nxt = PH_STEER;
      PH_STEER:    phase_nxt = PH_CHECK;
      PH_CHECK:    phase_nxt = PH_HUNT;
      default:     phase_nxt = (rx_byte == marker_r) ? PH_THROTTLE : PH_HUNT;
    endcase
  end

  assign sum = thr_r + brk_r + str_r;

  // Drop bad checksums and link-down packets silently
  assign pkt_valid = byte_accept && (phase_r == PH_CHECK) && (sum == rx_byte) && link_up;
  assign pkt.throttle = thr_r;
  assign pkt.brake    = brk_r;
  assign pkt.steering = str_r;

endmodule

// ----- rtl/spam_queue.sv -----
// Short packet queue decoupling the framer from the scaler.
`include "serial_packet_axis_mapper_defines.svh"

module spam_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spam_pkg::packet_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output spam_pkg::packet_t pop_data
);
  import spam_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  packet_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  `SPAM_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue pushed while full")
  `SPAM_ASSERT_NOW(a_no_underflow, pop, !empty, "queue popped while empty")
  `SPAM_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count stuck")

endmodule

// ----- rtl/spam_scaler.sv -----
// Back end: scales queued packets to axis values and holds the result beat.
module spam_scaler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  spam_pkg::packet_t                  q_data,
  output logic                               q_pop,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic        [spam_pkg::UAXIS_W-1:0] out_throttle_axis,
  output logic        [spam_pkg::UAXIS_W-1:0] out_brake_axis,
  output logic signed [spam_pkg::SAXIS_W-1:0] out_steering_axis
);
  import spam_pkg::*;

  // v*32767/255 = 128*v + floor(127*v/255); the tail needs one compare and subtract
  function automatic logic [UAXIS_W-1:0] scale_u(input logic [BYTE_W-1:0] v);
    logic [14:0] y;
    logic [6:0]  e;
    logic [8:0]  r;
    logic [6:0]  q;
    y = {v, 7'd0} - {7'd0, v};
    e = y[14:8];
    r = {1'b0, y[7:0]} + {2'd0, e};
    q = e + ((r >= 9'd255) ? 7'd1 : 7'd0);
    scale_u = {v, 7'd0} + {8'd0, q};
  endfunction

  // (s+128)*65534/255 = 257*o - (o != 0); then remove 32767 modulo 2^16
  function automatic logic [SAXIS_W-1:0] scale_s(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] o;
    o = raw ^ 8'h80;
    scale_s = {o, o} - {15'd0, (o != 8'd0)} - 16'd32767;
  endfunction

  logic                       valid_r;
  logic                       load;
  logic [UAXIS_W-1:0]         thr_r, brk_r;
  logic signed [SAXIS_W-1:0]  str_r;

  // Advance whenever the result register is free or being drained this cycle
  assign load  = !q_empty && (!valid_r || out_pop);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      thr_r <= scale_u(q_data.throttle);
      brk_r <= scale_u(q_data.brake);
      str_r <= signed'(scale_s(q_data.steering));
    end
  end

  assign out_empty         = !valid_r;
  assign out_throttle_axis = thr_r;
  assign out_brake_axis    = brk_r;
  assign out_steering_axis = str_r;

endmodule

// ----- rtl/serial_packet_axis_mapper.sv -----
// Top level of the serial packet axis mapper.
// Usage:
//   Input channel (push/full): one received serial byte per beat with the link
//   state. A byte is taken on any edge with in_push high and in_full low, so a
//   byte can enter every cycle.
//   The framer hunts for the start marker, captures throttle, brake and steering
//   unchecked, then tests the checksum byte; a good packet with the link up is
//   queued, a bad one or a link-down one is dropped without a result beat.
//   Result channel (empty/pop): the scaled axes of the oldest packet sit on the
//   out_ ports while out_empty is low; pop them with out_pop.
//   Path: after its checksum byte is taken, a result reaches the out_ ports via
//   the queue write, then the output register load, which waits while an
//   earlier result is still unpopped.
//   Throughput: one byte per cycle while in_full is low, limited by the framer's single byte port.
//   When the receiver stalls, results hold in the output register and the
//   packet queue (QUEUE_DEPTH entries); in_full rises only when that queue fills.
//   cfg_ready is always high; write cfg_start_marker only while the block is idle.
//   Reset (rst_n low, synchronous): marker back to 0xFF, framer back to hunting,
//   queue and result register emptied.
module serial_packet_axis_mapper #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic        [spam_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                                in_link_up,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic        [spam_pkg::UAXIS_W-1:0] out_throttle_axis,
  output logic        [spam_pkg::UAXIS_W-1:0] out_brake_axis,
  output logic signed [spam_pkg::SAXIS_W-1:0] out_steering_axis,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [spam_pkg::BYTE_W-1:0]  cfg_start_marker
);
  import spam_pkg::*;

  logic    byte_accept;
  logic    pkt_valid;
  packet_t pkt;
  logic    q_full, q_empty, q_pop;
  packet_t q_data;

  assign cfg_ready   = 1'b1;
  assign in_full     = q_full;
  assign byte_accept = in_push && !q_full;

  spam_framer u_framer (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_start_marker (cfg_start_marker),
    .byte_accept      (byte_accept),
    .rx_byte          (in_rx_byte),
    .link_up          (in_link_up),
    .pkt_valid        (pkt_valid),
    .pkt              (pkt)
  );

  spam_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pkt_valid),
    .push_data (pkt),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  spam_scaler u_scaler (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_throttle_axis (out_throttle_axis),
    .out_brake_axis    (out_brake_axis),
    .out_steering_axis (out_steering_axis)
  );

endmodule
